FILE: src/b64e_pkg.sv
// shared types, constants and the sextet-to-ascii map of the base64 encoder
`default_nettype none
package b64e_pkg;

	// ascii codes used by the encoder
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_PAD     = 8'h3D;

	// alphabet range boundaries
	localparam logic [5:0] N_UPPER = 6'd26;
	localparam logic [5:0] N_ALPHA = 6'd52;
	localparam logic [5:0] N_ALNUM = 6'd62;

	// position within a 3-byte group
	localparam logic [1:0] PH_FIRST  = 2'd0;
	localparam logic [1:0] PH_SECOND = 2'd1;
	localparam logic [1:0] PH_THIRD  = 2'd2;

	// characters caused by one byte, handed from front to back
	typedef struct packed {
		logic [3:0][7:0] chars;
		logic [1:0]      last_idx;
		logic            fin;
	} job_t;

	function automatic logic [7:0] sextet_to_ascii(input logic [5:0] v);
		logic [7:0] w;
		begin
			w = {2'b00, v};
			if (v < N_UPPER) return CH_UPPER_A + w;
			if (v < N_ALPHA) return CH_LOWER_A + w - {2'b00, N_UPPER};
			if (v < N_ALNUM) return CH_ZERO + w - {2'b00, N_ALPHA};
			if (v == N_ALNUM) return CH_PLUS;
			return CH_SLASH;
		end
	endfunction

endpackage
`default_nettype wire

FILE: src/b64e_byte_if.sv
// input channel carrying one raw message byte per request
`default_nettype none
interface b64e_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       final_byte;

	modport source (output valid, output data_byte, output final_byte, input ready);
	modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface
`default_nettype wire

FILE: src/b64e_char_if.sv
// output channel carrying one encoded character per request
`default_nettype none
interface b64e_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] symbol;
	logic       run_last;
	logic       message_end;

	modport source (output valid, output symbol, output run_last, output message_end,
		input ready);
	modport sink   (input valid, input symbol, input run_last, input message_end,
		output ready);
endinterface
`default_nettype wire

FILE: src/b64e_front.sv
// front end: takes bytes, tracks group phase and carry, builds character jobs
`default_nettype none
module b64e_front (
	input  wire logic         clk,
	input  wire logic         arst_n,
	b64e_byte_if.sink         raw,
	input  wire logic         full,
	output logic              push,
	output b64e_pkg::job_t    job
);
	import b64e_pkg::*;

	logic [1:0] phase_q;
	logic [3:0] carry_q;
	logic [1:0] nphase;
	logic [3:0] ncarry;
	logic [5:0] s0;
	logic [5:0] s1;

	assign raw.ready = !full;
	assign push      = raw.valid && !full;

	always_comb begin
		s0     = '0;
		s1     = '0;
		nphase = PH_SECOND;
		ncarry = '0;
		unique case (phase_q)
			PH_SECOND: begin
				s0     = {carry_q[1:0], raw.data_byte[7:4]};
				nphase = PH_THIRD;
				ncarry = raw.data_byte[3:0];
			end
			PH_THIRD: begin
				s0     = {carry_q, raw.data_byte[7:6]};
				s1     = raw.data_byte[5:0];
				nphase = PH_FIRST;
				ncarry = '0;
			end
			default: begin
				// unused phase code behaves as start of group
				s0     = raw.data_byte[7:2];
				nphase = PH_SECOND;
				ncarry = {2'b00, raw.data_byte[1:0]};
			end
		endcase

		job.chars[0] = sextet_to_ascii(s0);
		job.chars[1] = sextet_to_ascii(s1);
		job.chars[2] = CH_PAD;
		job.chars[3] = CH_PAD;
		job.last_idx = (nphase == PH_FIRST) ? 2'd1 : 2'd0;
		job.fin      = raw.final_byte;

		if (raw.final_byte) begin
			// flush leftover bits zero-padded, then pad to four characters
			unique case (nphase)
				PH_SECOND: begin
					job.chars[1] = sextet_to_ascii({ncarry[1:0], 4'b0000});
					job.last_idx = 2'd3;
				end
				PH_THIRD: begin
					job.chars[1] = sextet_to_ascii({ncarry, 2'b00});
					job.last_idx = 2'd2;
				end
				default: begin
				end
			endcase
			nphase = PH_FIRST;
			ncarry = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			carry_q <= '0;
		end else if (push) begin
			phase_q <= nphase;
			carry_q <= ncarry;
		end
	end

	a_phase_legal: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != 2'd3)
		else $error("group phase left its legal range");

endmodule
`default_nettype wire

FILE: src/b64e_fifo.sv
// short job queue between front and back end
`default_nettype none
module b64e_fifo #(
	parameter int DEPTH = 2
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire b64e_pkg::job_t wr_job,
	input  wire logic           pop,
	output b64e_pkg::job_t      head,
	output logic                full,
	output logic                empty
);
	import b64e_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("job queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("job queue read while empty");

endmodule
`default_nettype wire

FILE: src/b64e_back.sv
// back end: walks each job one character per cycle into the output register, unless stalled
`default_nettype none
module b64e_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire b64e_pkg::job_t head,
	input  wire logic           empty,
	output logic                pop,
	b64e_char_if.source         code
);
	import b64e_pkg::*;

	logic       out_valid_q;
	logic [7:0] symbol_q;
	logic       run_last_q;
	logic       message_end_q;
	logic [1:0] idx_q;
	logic       load;
	logic       at_last;

	assign load    = !empty && (!out_valid_q || code.ready);
	assign at_last = (idx_q == head.last_idx);
	assign pop     = load && at_last;

	assign code.valid       = out_valid_q;
	assign code.symbol      = symbol_q;
	assign code.run_last    = run_last_q;
	assign code.message_end = message_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= at_last ? 2'd0 : idx_q + 1'b1;
			end else if (code.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			symbol_q      <= head.chars[idx_q];
			run_last_q    <= at_last;
			message_end_q <= at_last && head.fin;
		end
	end

	a_idx_in_job: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> idx_q <= head.last_idx)
		else $error("character index ran past end of job");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && message_end_q) |-> run_last_q)
		else $error("message end flagged on a character that ends no byte");

endmodule
`default_nettype wire

FILE: src/base64_stream_encoder.sv
// top level of the streaming base64 encoder
`default_nettype none
// Streaming Base64 encoder (standard alphabet, '=' padding). Bytes arrive on
// raw, one per request, most significant bit first; final_byte marks the last
// byte of a message. Characters leave on code, one per request: run_last marks
// the last character a byte caused and message_end the last of the message,
// after which the encoder starts a fresh group. A byte can be taken every
// cycle while the job queue has room; the front end turns it into a job of one
// to four characters in the cycle it is taken. The back end moves one character
// per cycle into the output register while the output is accepted. A byte
// yields one or two characters, four per three bytes on average in a long
// message, and up to four for a final byte. A byte's characters pass through
// the job queue and then the output register. Throughput is set by the single
// output register; QUEUE_DEPTH jobs let input and output stall independently.
module base64_stream_encoder #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	b64e_byte_if.sink   raw,
	b64e_char_if.source code
);
	import b64e_pkg::*;

	// front to queue
	logic push;
	job_t new_job;
	logic full;

	// queue to back
	job_t head;
	logic empty;
	logic pop;

	// classifies each byte and builds its characters
	b64e_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.raw    (raw),
		.full   (full),
		.push   (push),
		.job    (new_job)
	);

	// decouples byte intake from character output
	b64e_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (new_job),
		.pop    (pop),
		.head   (head),
		.full   (full),
		.empty  (empty)
	);

	// emits one character per cycle from the head job while the output is accepted
	b64e_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (empty),
		.pop    (pop),
		.code   (code)
	);

	// every accepted request is mirrored by a queue write
	a_accept_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		(raw.valid && raw.ready) |-> push)
		else $error("request accepted without a queue write");

endmodule
`default_nettype wire
